### sv/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared word type, round constants, initial hash values and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef logic [31:0] t_word;

    localparam int NUM_ROUNDS = 64;
    localparam int NUM_WORDS  = 8;
    localparam int WIN_WORDS  = 16;

    localparam t_word ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_HASH [NUM_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       wr_byte;   // store the input byte and count it
        logic       pad;       // place the 0x80 marker and zero the tail
        logic       clr_low;   // zero words 0 to 13 of the block
        logic       put_len;   // place the bit count in words 14 and 15
        logic       load;      // copy the hash into the working variables
        logic       round;     // run one compression round
        logic       add;       // fold the working variables into the hash
        logic       fin;       // fold into the digest and restart the hash
        logic [5:0] rnd;       // round number for the constant table
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic blk_full;    // the next byte completes a block
        logic pad_spill;   // padding at this fill level needs an extra block
        logic out_busy;    // the digest is still being delivered
    } t_status;

endpackage

### sv/sha256_dpath.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block window with the message schedule, the shared round unit, the hash
// registers, the byte count and the digest output register.
// ----------------------------------------------------------------------------
module sha256_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha256_pkg::t_cmd     i_cmd,
    input  logic [7:0]           i_data_byte,
    output sha256_pkg::t_status  o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output sha256_pkg::t_word    o_digest_word,
    output logic [2:0]           o_word_index,
    output logic                 o_final_word
);

    localparam logic [2:0] LAST_WORD = 3'(sha256_pkg::NUM_WORDS - 1);

    function automatic sha256_pkg::t_word f_bsig0(input sha256_pkg::t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic sha256_pkg::t_word f_bsig1(input sha256_pkg::t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic sha256_pkg::t_word f_ssig0(input sha256_pkg::t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic sha256_pkg::t_word f_ssig1(input sha256_pkg::t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    sha256_pkg::t_word r_win  [sha256_pkg::WIN_WORDS];
    sha256_pkg::t_word n_win  [sha256_pkg::WIN_WORDS];
    sha256_pkg::t_word r_wk   [sha256_pkg::NUM_WORDS];
    sha256_pkg::t_word n_wk   [sha256_pkg::NUM_WORDS];
    sha256_pkg::t_word r_hash [sha256_pkg::NUM_WORDS];
    sha256_pkg::t_word r_dig  [sha256_pkg::NUM_WORDS];
    logic [60:0]       r_count;
    logic              r_out_valid;
    logic [2:0]        r_out_idx;

    logic [5:0]        pos;
    logic [63:0]       bit_len;
    logic              out_take;
    sha256_pkg::t_word t1;
    sha256_pkg::t_word t2;
    sha256_pkg::t_word w_next;

    assign pos      = r_count[5:0];
    assign bit_len  = {r_count, 3'b000};
    assign out_take = r_out_valid & i_out_ready;

    assign o_status.blk_full  = (pos == 6'd63);
    assign o_status.pad_spill = (pos[5:3] == 3'b111);
    assign o_status.out_busy  = r_out_valid;

    assign o_out_valid   = r_out_valid;
    assign o_digest_word = r_dig[0];
    assign o_word_index  = r_out_idx;
    assign o_final_word  = (r_out_idx == LAST_WORD);

    // One round: a..h live in r_wk[0]..r_wk[7].
    assign t1 = r_wk[7] + f_bsig1(r_wk[4]) + ((r_wk[4] & r_wk[5]) ^ (~r_wk[4] & r_wk[6]))
              + sha256_pkg::ROUND_K[i_cmd.rnd] + r_win[0];
    assign t2 = f_bsig0(r_wk[0])
              + ((r_wk[0] & r_wk[1]) ^ (r_wk[0] & r_wk[2]) ^ (r_wk[1] & r_wk[2]));
    assign w_next = r_win[0] + f_ssig0(r_win[1]) + r_win[9] + f_ssig1(r_win[14]);

    always_comb begin
        logic [5:0] v_idx;
        v_idx = '0;
        n_win = r_win;
        if (i_cmd.round) begin
            for (int i = 0; i < sha256_pkg::WIN_WORDS - 1; i++) begin
                n_win[i] = r_win[i + 1];
            end
            n_win[sha256_pkg::WIN_WORDS - 1] = w_next;
        end
        if (i_cmd.wr_byte) begin
            n_win[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = i_data_byte;
        end
        if (i_cmd.pad) begin
            for (int i = 0; i < sha256_pkg::WIN_WORDS; i++) begin
                for (int j = 0; j < 4; j++) begin
                    v_idx = 6'(i * 4 + j);
                    if (v_idx == pos) begin
                        n_win[i][8 * (3 - j) +: 8] = 8'h80;
                    end else if (v_idx > pos) begin
                        n_win[i][8 * (3 - j) +: 8] = 8'h00;
                    end
                end
            end
        end
        if (i_cmd.clr_low) begin
            for (int i = 0; i < sha256_pkg::WIN_WORDS - 2; i++) begin
                n_win[i] = '0;
            end
        end
        if (i_cmd.put_len) begin
            n_win[sha256_pkg::WIN_WORDS - 2] = bit_len[63:32];
            n_win[sha256_pkg::WIN_WORDS - 1] = bit_len[31:0];
        end
    end

    always_comb begin
        n_wk = r_wk;
        if (i_cmd.load) begin
            n_wk = r_hash;
        end else if (i_cmd.round) begin
            n_wk[0] = t1 + t2;
            n_wk[1] = r_wk[0];
            n_wk[2] = r_wk[1];
            n_wk[3] = r_wk[2];
            n_wk[4] = r_wk[3] + t1;
            n_wk[5] = r_wk[4];
            n_wk[6] = r_wk[5];
            n_wk[7] = r_wk[6];
        end
    end

    // Payload storage without reset.
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_wk  <= n_wk;
        if (i_cmd.fin) begin
            for (int i = 0; i < sha256_pkg::NUM_WORDS; i++) begin
                r_dig[i] <= r_hash[i] + r_wk[i];
            end
        end else if (out_take) begin
            for (int i = 0; i < sha256_pkg::NUM_WORDS - 1; i++) begin
                r_dig[i] <= r_dig[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= sha256_pkg::INIT_HASH;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_out_idx   <= '0;
        end else begin
            if (i_cmd.fin) begin
                r_hash  <= sha256_pkg::INIT_HASH;
                r_count <= '0;
            end else begin
                if (i_cmd.add) begin
                    for (int i = 0; i < sha256_pkg::NUM_WORDS; i++) begin
                        r_hash[i] <= r_hash[i] + r_wk[i];
                    end
                end
                if (i_cmd.wr_byte) begin
                    r_count <= r_count + 61'd1;
                end
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
                r_out_idx   <= '0;
            end else if (out_take) begin
                r_out_idx <= r_out_idx + 3'd1;
                if (r_out_idx == LAST_WORD) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

endmodule

### sv/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, the 64 compression rounds and the hash
// update, and hands the finished digest to the output register.
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_byte_valid,
    input  logic                 i_last,
    input  sha256_pkg::t_status  i_status,
    output logic                 o_ready,
    output sha256_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_ROUND,
        S_ADD
    } t_state;

    // What follows the hash update of the block in flight.
    typedef enum logic [1:0] {
        AF_NONE,
        AF_PAD,
        AF_LEN_CLR,
        AF_FINAL
    } t_after;

    localparam logic [5:0] LAST_ROUND = 6'(sha256_pkg::NUM_ROUNDS - 1);

    t_state     r_state, n_state;
    t_after     r_after, n_after;
    logic [5:0] r_rnd, n_rnd;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_rnd   = r_rnd;
        o_cmd   = '0;
        o_cmd.rnd = r_rnd;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    if (i_byte_valid) begin
                        o_cmd.wr_byte = 1'b1;
                        if (i_status.blk_full) begin
                            o_cmd.load = 1'b1;
                            n_rnd      = '0;
                            n_after    = i_last ? AF_PAD : AF_NONE;
                            n_state    = S_ROUND;
                        end else if (i_last) begin
                            n_state = S_PAD;
                        end
                    end else if (i_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.pad = 1'b1;
                if (i_status.pad_spill) begin
                    o_cmd.load = 1'b1;
                    n_rnd      = '0;
                    n_after    = AF_LEN_CLR;
                    n_state    = S_ROUND;
                end else begin
                    n_after = AF_NONE;
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.put_len = 1'b1;
                o_cmd.clr_low = (r_after == AF_LEN_CLR);
                o_cmd.load    = 1'b1;
                n_rnd         = '0;
                n_after       = AF_FINAL;
                n_state       = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_rnd       = r_rnd + 6'd1;
                if (r_rnd == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                case (r_after)
                    AF_FINAL: begin
                        // Hold until the previous digest has left.
                        if (!i_status.out_busy) begin
                            o_cmd.fin = 1'b1;
                            n_after   = AF_NONE;
                            n_state   = S_IDLE;
                        end
                    end
                    AF_PAD: begin
                        o_cmd.add = 1'b1;
                        n_state   = S_PAD;
                    end
                    AF_LEN_CLR: begin
                        o_cmd.add = 1'b1;
                        n_state   = S_LEN;
                    end
                    default: begin
                        o_cmd.add = 1'b1;
                        n_state   = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= AF_NONE;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_rnd   <= n_rnd;
        end
    end

endmodule

### sv/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream with SHA-256 and delivers the eight digest words.
// ----------------------------------------------------------------------------
// Usage. The input channel carries one item per byte position: s_axis_tdata
// holds the message byte, s_axis_tuser says whether that byte belongs to the
// message, and s_axis_tlast ends the message. An item with tlast and no byte
// finishes the message as it stands, so an empty message is hashed too.
// An item without a byte and without tlast changes nothing.
// Flow. The input is ready while the controller is idle. The byte that
// completes a 64-byte block starts the shared round unit, and the input
// stays not ready through the 64 rounds and the hash update, so no new byte
// is taken while a block is in flight. After tlast, the block pads the
// message, places the length, runs the 64 rounds of the last block and folds
// the result into the digest register; when the padding spills into an extra
// block or tlast comes with the byte that completes a block, one more block
// of 64 rounds comes first.
// Output. The digest leaves on the master channel as eight items, most
// significant word first; tuser gives the word index and tlast marks the
// eighth word. The digest sits in its own register, so the next message is
// taken while the receiver stalls; only its own final hash update waits
// until the previous digest has been fully taken.
// Reset. A synchronous low reset restores the initial hash values, clears
// the byte count and drops any digest that was still waiting.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tuser,    // [0] byte_valid
    input  logic        s_axis_tlast,    // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,    // [2:0] word_index
    output logic        m_axis_tlast     // final_word
);

    sha256_pkg::t_cmd    cmd;
    sha256_pkg::t_status status;
    logic                in_accept;

    assign in_accept = s_axis_tvalid & s_axis_tready;

    sha256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_byte_valid (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .i_status     (status),
        .o_ready      (s_axis_tready),
        .o_cmd        (cmd)
    );

    sha256_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (s_axis_tdata),
        .o_status      (status),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_digest_word (m_axis_tdata),
        .o_word_index  (m_axis_tuser),
        .o_final_word  (m_axis_tlast)
    );

endmodule

### sv/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher checker
// Port-level checks on the digest output sequence, bound to the top level.
// ----------------------------------------------------------------------------
module sha256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled digest item holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("digest item changed while stalled");

    // The last marker sits exactly on word seven.
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("tlast does not match word index");

    // A digest always starts with word zero.
    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> (m_axis_tuser == 3'd0))
        else $error("digest did not start at word zero");

    // Within a digest the words follow without gaps in index order.
    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1)))
        else $error("digest words out of sequence");

    // Reset leaves no digest pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("digest valid after reset");

endmodule

bind sha256_stream_hasher sha256_checker u_sha256_checker (.*);

### test/sha256_stream_hasher_chk.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher checker
// Watches both stream channels, keeps its own SHA-256 state, works out the
// eight digest words of every finished message and compares each delivered
// digest item with the oldest one still owed.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,     // [7:0] data_byte
    input  logic        i_in_user,     // [0] byte_valid
    input  logic        i_in_last,     // end_of_message
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,    // [31:0] digest_word
    input  logic [2:0]  i_out_user,    // [2:0] word_index
    input  logic        i_out_last,    // final_word
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam int         LEN_OFFSET = 56;
    localparam int         MAX_REPORTS = 10;

    typedef struct packed {
        sha256_pkg::t_word word;
        logic [2:0]        index;
        logic              last;
    } t_digest_item;

    sha256_pkg::t_word chain [sha256_pkg::NUM_WORDS];
    logic [7:0]        blk [64];
    logic [60:0]       msg_len;
    t_digest_item      digests_due [$];
    int                mismatches = 0;

    function automatic sha256_pkg::t_word rotr(sha256_pkg::t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One compression of the 64 bytes in blk into the chaining value.
    function automatic void absorb_block();
        sha256_pkg::t_word sched [sha256_pkg::NUM_ROUNDS];
        sha256_pkg::t_word a, b, c, d, e, f, g, h;
        sha256_pkg::t_word s0, s1, t1, t2;
        for (int r = 0; r < sha256_pkg::WIN_WORDS; r++) begin
            sched[r] = {blk[4 * r], blk[4 * r + 1], blk[4 * r + 2], blk[4 * r + 3]};
        end
        for (int r = sha256_pkg::WIN_WORDS; r < sha256_pkg::NUM_ROUNDS; r++) begin
            s0 = rotr(sched[r - 15], 7) ^ rotr(sched[r - 15], 18) ^ (sched[r - 15] >> 3);
            s1 = rotr(sched[r - 2], 17) ^ rotr(sched[r - 2], 19) ^ (sched[r - 2] >> 10);
            sched[r] = sched[r - 16] + s0 + sched[r - 7] + s1;
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int r = 0; r < sha256_pkg::NUM_ROUNDS; r++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + sha256_pkg::ROUND_K[r] + sched[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function automatic void store_byte(logic [7:0] data);
        int pos;
        pos = int'(msg_len[5:0]);
        blk[pos] = data;
        msg_len = msg_len + 61'd1;
        if (pos == 63) absorb_block();
    endfunction

    // Padding (with an extra compression when it spills), length field, final compression, then the digest is owed.
    function automatic void close_message();
        int          pos;
        logic [63:0] bit_len;
        pos = int'(msg_len[5:0]);
        blk[pos] = PAD_BYTE;
        for (int i = pos + 1; i < 64; i++) blk[i] = 8'h00;
        if (pos >= LEN_OFFSET) begin
            absorb_block();
            for (int i = 0; i < LEN_OFFSET; i++) blk[i] = 8'h00;
        end
        bit_len = {msg_len, 3'b000};
        for (int k = 0; k < 8; k++) blk[LEN_OFFSET + k] = bit_len[63 - 8 * k -: 8];
        absorb_block();
        for (int k = 0; k < sha256_pkg::NUM_WORDS; k++) begin
            digests_due.push_back('{chain[k], 3'(k), k == sha256_pkg::NUM_WORDS - 1});
        end
        chain   = sha256_pkg::INIT_HASH;
        msg_len = '0;
    endfunction

    always @(posedge i_clk) begin
        t_digest_item got;
        t_digest_item want;
        if (!i_rst_n) begin
            chain   = sha256_pkg::INIT_HASH;
            msg_len = '0;
            digests_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_out_data, i_out_user, i_out_last};
                if (digests_due.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected digest item: word %h index %0d last %b",
                                 got.word, got.index, got.last);
                    mismatches++;
                end else begin
                    want = digests_due.pop_front();
                    if (got !== want) begin
                        if (mismatches < MAX_REPORTS)
                            $display({"digest item mismatch: expected word %h index %0d ",
                                      "last %b, got word %h index %0d last %b"},
                                     want.word, want.index, want.last,
                                     got.word, got.index, got.last);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_user) store_byte(i_in_data);
                if (i_in_last) close_message();
            end
        end
        o_pending    <= digests_due.size();
        o_fail_count <= mismatches;
    end

endmodule

### test/sha256_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte streams with random gaps and output stalls, lets the checker
// predict and compare every digest item, and gives the verdict.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;

    // A stretch this long with no item moving on either channel means the
    // block is stuck. The slowest legal stretch is a spilling pad block
    // followed by the longest output stall.
    localparam int IDLE_LIMIT  = 4000;
    // Quiet time at the end, longer than the worst digest latency.
    localparam int TAIL_CYCLES = 200;
    localparam int RANDOM_ITEMS = 140;
    // A full block followed by a pad that spills into an extra block.
    localparam int LONG_MSG_BYTES = 120;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;    // [7:0] data_byte
    logic        s_axis_tuser  = 1'b0;     // [0] byte_valid
    logic        s_axis_tlast  = 1'b0;     // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;             // [31:0] digest_word
    logic [2:0]  m_axis_tuser;             // [2:0] word_index
    logic        m_axis_tlast;             // final_word

    int fail_count;
    int pending;
    int idle_cycles = 0;

    // When set, the sender puts no gaps between items of the current message.
    bit steady = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sha256_stream_hasher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha256_stream_hasher_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap(bit quiet);
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 16);
        return $urandom_range(30, 200);
    endfunction

    // Presents one item after an optional gap and returns in the time step of
    // the edge that accepted it. tvalid is left high so that a following item
    // without a gap goes out back to back; whoever lets time pass next without
    // a new item must lower it in that same step.
    task automatic send_item(input logic [7:0] data_byte, input logic has_byte,
                             input logic ends);
        int gap;
        gap = pick_gap(steady);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data_byte;
        s_axis_tuser  <= has_byte;
        s_axis_tlast  <= ends;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Holds the input off until every owed digest item has been delivered.
    // The pending count is registered, so the task always waits for an edge
    // before it looks at the count.
    task automatic wait_digests_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Output side: ready runs broken by stalls, with an occasional long run
    // of steady ready so that digests also leave back to back.
    initial begin
        int stall;
        int run;
        forever begin
            stall = pick_gap(1'b0);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                              : $urandom_range(1, 12);
            repeat (run) @(posedge i_clk);
        end
    end

    // The watchdog counts edges at which no item moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int       msg_items;
        int       messages;
        int       nbytes;
        bit       merge_end;
        int       boundary_len [4];
        boundary_len = '{55, 56, 57, 63};
        msg_items = 0;
        messages  = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The empty message comes first, straight out of reset.
        send_item(8'h5a, 1'b0, 1'b1);
        // An item with neither a byte nor the end must change nothing.
        send_item(8'hff, 1'b0, 1'b0);
        // "abc", the last byte arriving together with the end of message.
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // All-zero and all-one bytes, an ignored item in the middle, then an
        // end that carries no byte.
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'hc3, 1'b0, 1'b0);
        send_item(8'h3c, 1'b0, 1'b1);
        // Two empty messages right after a digest, then one-byte messages.
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        wait_digests_drained();

        // Random part: whole messages with random bytes. The first one fills a
        // block and then spills its padding into an extra block; later ones are
        // short mostly, with lengths around the pad boundary now and then.
        while (msg_items < RANDOM_ITEMS) begin
            if (messages == 0)
                nbytes = LONG_MSG_BYTES;
            else if ($urandom_range(0, 7) == 0)
                nbytes = boundary_len[$urandom_range(0, 3)];
            else
                nbytes = $urandom_range(0, 16);
            steady    = ($urandom_range(0, 3) == 0);
            merge_end = $urandom_range(0, 1);
            for (int i = 0; i < nbytes; i++) begin
                if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
                send_item(8'($urandom), 1'b1, merge_end && (i == nbytes - 1));
                msg_items++;
            end
            if (nbytes == 0 || !merge_end) begin
                send_item(8'($urandom), 1'b0, 1'b1);
                msg_items++;
            end
            messages++;
            if ($urandom_range(0, 4) == 0) wait_digests_drained();
        end
        steady = 1'b0;

        // Let every owed digest arrive, then give the block a quiet tail.
        wait_digests_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
